>>> hdl/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the epoch-seconds to UTC calendar converter:
// divider digit size, calendar constants and reciprocal multipliers.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int DIGIT_W = 4;

    localparam int SECS_PER_DAY = 86400;
    localparam int DAY_SHIFT    = 7;
    localparam int DAY_ODD      = 675;
    localparam int ERA_DAYS     = 146097;
    localparam int CIVIL_SHIFT  = 719468;
    localparam int LAST_DOE     = 146096;

    localparam int REM_W  = 17;
    localparam int DOE_W  = 18;
    localparam int YOE_W  = 9;
    localparam int DOY_W  = 9;
    localparam int MP_W   = 4;
    localparam int YEAR_W = 16;
    localparam int MTOT_W = 11;

    // floor(x / D) == (x * M) >> S for every x of the stated width
    localparam int S_DIV1460  = 29;
    localparam logic [18:0] M_DIV1460 =
        19'(((64'd1 << S_DIV1460) + 64'd1459) / 64'd1460);
    localparam int S_DIV36524 = 34;
    localparam logic [18:0] M_DIV36524 =
        19'(((64'd1 << S_DIV36524) + 64'd36523) / 64'd36524);
    localparam int S_DIV365   = 27;
    localparam logic [18:0] M_DIV365 =
        19'(((64'd1 << S_DIV365) + 64'd364) / 64'd365);
    localparam int S_DIV7     = 21;
    localparam logic [18:0] M_DIV7 =
        19'(((64'd1 << S_DIV7) + 64'd6) / 64'd7);
    localparam int S_DIV60    = 23;
    localparam logic [17:0] M_DIV60 =
        18'(((64'd1 << S_DIV60) + 64'd59) / 64'd60);
    localparam int S_DIV3600  = 29;
    localparam logic [17:0] M_DIV3600 =
        18'(((64'd1 << S_DIV3600) + 64'd3599) / 64'd3600);
    localparam int S_DIV100   = 16;
    localparam logic [9:0] M_DIV100 =
        10'(((64'd1 << S_DIV100) + 64'd99) / 64'd100);
    localparam int S_DIV153   = 19;
    localparam logic [11:0] M_DIV153 =
        12'(((64'd1 << S_DIV153) + 64'd152) / 64'd153);

    typedef logic [DOE_W-1:0]  t_doe;
    typedef logic [REM_W-1:0]  t_rem;
    typedef logic [YOE_W-1:0]  t_yoe;
    typedef logic [DOY_W-1:0]  t_doy;
    typedef logic [MP_W-1:0]   t_mp;
    typedef logic [YEAR_W-1:0] t_year;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } t_tod;

    // days from March 1 to the first of each March-based month
    localparam t_doy MP_DAYS_BEFORE [0:11] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    localparam t_mp MP_JANUARY = 4'd10;

endpackage

>>> hdl/esc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_in_if
// Input channel: one signed epoch-seconds value per transfer.
// ----------------------------------------------------------------------------
interface esc_in_if #(
    parameter int EPOCH_SECONDS_WIDTH = 40
) ();
    logic                                  valid;
    logic                                  ready;
    logic signed [EPOCH_SECONDS_WIDTH-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

>>> hdl/esc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_out_if
// Output channel: one broken-down UTC calendar time per transfer.
// ----------------------------------------------------------------------------
interface esc_out_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] year_since_1900;
    logic        [3:0]  month_index;
    logic        [4:0]  day_of_month;
    logic        [2:0]  weekday;
    logic        [8:0]  day_of_year;
    logic        [4:0]  hour_of_day;
    logic        [5:0]  minute_of_hour;
    logic        [5:0]  second_of_minute;

    modport source (
        output valid, output year_since_1900, output month_index, output day_of_month,
        output weekday, output day_of_year, output hour_of_day, output minute_of_hour,
        output second_of_minute, input ready
    );
    modport sink (
        input valid, input year_since_1900, input month_index, input day_of_month,
        input weekday, input day_of_year, input hour_of_day, input minute_of_hour,
        input second_of_minute, output ready
    );
endinterface

>>> hdl/esc_cdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_cdiv
// Pipelined unsigned division by a constant, one DIGIT_W-bit quotient digit
// per stage, with a sideband word carried alongside and per-stage flow control.
// ----------------------------------------------------------------------------
module esc_cdiv import esc_pkg::*; #(
    parameter int WIDTH   = 33,
    parameter int DIVISOR = 675,
    parameter int SIDE_W  = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [WIDTH-1:0]            i_dividend,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [WIDTH-1:0]            o_quotient,
    output logic [$clog2(DIVISOR)-1:0]  o_remainder,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int RW   = $clog2(DIVISOR);
    localparam int NSTG = (WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int PW   = NSTG * DIGIT_W;
    localparam int VW   = RW + DIGIT_W;

    logic [NSTG-1:0]   r_v;
    logic [RW-1:0]     r_rem  [NSTG];
    logic [PW-1:0]     r_work [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    logic [NSTG-1:0]   n_v;
    logic [RW-1:0]     n_rem  [NSTG];
    logic [PW-1:0]     n_work [NSTG];
    logic [SIDE_W-1:0] n_side [NSTG];
    logic [NSTG:0]     en;

    always_comb begin
        en[NSTG] = i_ready;
        for (int s = NSTG - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    always_comb begin
        for (int s = 0; s < NSTG; s++) begin
            logic [RW-1:0]      rin;
            logic [PW-1:0]      win;
            logic [VW-1:0]      v;
            logic [DIGIT_W-1:0] q;
            if (s == 0) begin
                n_v[s]    = i_valid;
                rin       = '0;
                win       = PW'(i_dividend);
                n_side[s] = i_side;
            end else begin
                n_v[s]    = r_v[s-1];
                rin       = r_rem[s-1];
                win       = r_work[s-1];
                n_side[s] = r_side[s-1];
            end
            v = {rin, win[PW-1 -: DIGIT_W]};
            q = '0;
            for (int j = 1; j < (1 << DIGIT_W); j++) begin
                if (v >= VW'(j * DIVISOR)) begin
                    q = DIGIT_W'(j);
                end
            end
            n_rem[s]  = RW'(v - VW'(q) * VW'(DIVISOR));
            n_work[s] = {win[PW-DIGIT_W-1:0], q};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSTG; s++) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en[s]) begin
                r_v[s] <= n_v[s];
            end
            if (en[s]) begin
                r_rem[s]  <= n_rem[s];
                r_work[s] <= n_work[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_ready     = en[0];
    assign o_valid     = r_v[NSTG-1];
    assign o_quotient  = r_work[NSTG-1][WIDTH-1:0];
    assign o_remainder = r_rem[NSTG-1];
    assign o_side      = r_side[NSTG-1];

endmodule

>>> hdl/epoch_seconds_to_utc_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar
// Converts signed Unix seconds to broken-down proleptic Gregorian UTC time.
//
//   Channel  Dir  Payload
//   i_in     in   epoch_seconds (EPOCH_SECONDS_WIDTH bits, signed)
//   o_out    out  year_since_1900, month_index, day_of_month, weekday,
//                 day_of_year, hour_of_day, minute_of_hour, second_of_minute
//
// One transfer per cycle in and out while the output side is ready. The two
// digit-serial constant dividers split off seconds per day and days per era.
// Reset clears only the stage valid bits. On a stall a full stage holds while
// its successor cannot advance, and empty stages keep filling.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar import esc_pkg::*; #(
    parameter int EPOCH_SECONDS_WIDTH = 40
) (
    input logic       i_clk,
    input logic       i_rst_n,
    esc_in_if.sink    i_in,
    esc_out_if.source o_out
);

    localparam int W   = EPOCH_SECONDS_WIDTH;
    localparam int Q1W = W - DAY_SHIFT;
    localparam int ZW  = ((W - 16 > 21) ? W - 16 : 21) + 1;
    localparam int NST = 7;

    localparam logic [63:0] BIAS1 = 64'd1 << (W - 1);
    localparam logic [63:0] QB1   = BIAS1 / 64'(SECS_PER_DAY);
    localparam logic [63:0] RB1   = BIAS1 % 64'(SECS_PER_DAY);
    localparam logic [63:0] BIAS2 = 64'd1 << (ZW - 1);
    localparam logic [63:0] QB2   = BIAS2 / 64'(ERA_DAYS);
    localparam logic [63:0] RB2   = BIAS2 % 64'(ERA_DAYS);
    localparam logic [ZW-1:0] ZOFF  = ZW'(QB1 - 64'(CIVIL_SHIFT));
    localparam logic [ZW-1:0] ZSIGN = ZW'(1) << (ZW - 1);

    // ---------------- day split: seconds / 86400 ----------------
    logic [W-1:0]         in_u;
    logic                 d1_ready;
    logic                 d1_valid;
    logic [Q1W-1:0]       d1_quo;
    logic [9:0]           d1_rem;
    logic [DAY_SHIFT-1:0] d1_side;
    logic                 en_b;

    assign in_u       = {~i_in.epoch_seconds[W-1], i_in.epoch_seconds[W-2:0]};
    assign i_in.ready = d1_ready;

    esc_cdiv #(
        .WIDTH   (Q1W),
        .DIVISOR (DAY_ODD),
        .SIDE_W  (DAY_SHIFT)
    ) u_div_day (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (d1_ready),
        .i_dividend  (in_u[W-1:DAY_SHIFT]),
        .i_side      (in_u[DAY_SHIFT-1:0]),
        .o_valid     (d1_valid),
        .i_ready     (en_b),
        .o_quotient  (d1_quo),
        .o_remainder (d1_rem),
        .o_side      (d1_side)
    );

    // ---------------- remove bias, shift to March-based day ----------------
    logic          r_vb;
    logic [ZW-1:0] r_uz;
    t_rem          r_b_rem;
    logic          d2_ready;
    t_rem          rem_u;
    logic          brw1;
    logic [ZW-1:0] z;

    assign en_b  = !r_vb || d2_ready;
    assign rem_u = {d1_rem, d1_side};
    assign brw1  = rem_u < REM_W'(RB1);
    assign z     = d1_quo[ZW-1:0] - ZOFF - ZW'(brw1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en_b) begin
            r_vb <= d1_valid;
        end
        if (en_b) begin
            r_uz    <= z ^ ZSIGN;
            r_b_rem <= rem_u - REM_W'(RB1) + (brw1 ? REM_W'(SECS_PER_DAY) : '0);
        end
    end

    // ---------------- era split: day / 146097 ----------------
    logic          d2_valid;
    logic [ZW-1:0] d2_quo;
    t_doe          d2_rem;
    t_rem          d2_side;
    logic [NST:0]  en;
    logic [NST-1:0] r_v;

    esc_cdiv #(
        .WIDTH   (ZW),
        .DIVISOR (ERA_DAYS),
        .SIDE_W  (REM_W)
    ) u_div_era (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_vb),
        .o_ready     (d2_ready),
        .i_dividend  (r_uz),
        .i_side      (r_b_rem),
        .o_valid     (d2_valid),
        .i_ready     (en[0]),
        .o_quotient  (d2_quo),
        .o_remainder (d2_rem),
        .o_side      (d2_side)
    );

    always_comb begin
        en[NST] = o_out.ready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= (k == 0) ? d2_valid : r_v[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // ---------------- C: era and day of era ----------------
    logic  [15:0] r_c_era;
    t_doe         r_c_doe;
    t_rem         r_c_rem;
    logic         brw2;

    assign brw2 = d2_rem < DOE_W'(RB2);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_c_era <= d2_quo[15:0] - 16'(QB2) - 16'(brw2);
            r_c_doe <= d2_rem - DOE_W'(RB2) + (brw2 ? DOE_W'(ERA_DAYS) : '0);
            r_c_rem <= d2_side;
        end
    end

    // ---------------- D: reciprocal products ----------------
    t_doe              r_d_doe;
    t_rem              r_d_rem;
    t_year             r_d_yb;
    logic [6:0]        r_d_q1460;
    logic [2:0]        r_d_q36524;
    logic [14:0]       r_d_q7;
    logic [MTOT_W-1:0] r_d_mtot;
    logic [4:0]        r_d_hour;
    logic [36:0]       p1460;
    logic [36:0]       p36524;
    logic [36:0]       p7;
    logic [34:0]       p60;
    logic [34:0]       p3600;

    assign p1460  = 37'(r_c_doe) * 37'(M_DIV1460);
    assign p36524 = 37'(r_c_doe) * 37'(M_DIV36524);
    assign p7     = 37'(r_c_doe + DOE_W'(3)) * 37'(M_DIV7);
    assign p60    = 35'(r_c_rem) * 35'(M_DIV60);
    assign p3600  = 35'(r_c_rem) * 35'(M_DIV3600);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_d_doe    <= r_c_doe;
            r_d_rem    <= r_c_rem;
            r_d_yb     <= r_c_era * 16'd400 - 16'd1900;
            r_d_q1460  <= p1460[S_DIV1460 +: 7];
            r_d_q36524 <= p36524[S_DIV36524 +: 3];
            r_d_q7     <= p7[S_DIV7 +: 15];
            r_d_mtot   <= p60[S_DIV60 +: MTOT_W];
            r_d_hour   <= p3600[S_DIV3600 +: 5];
        end
    end

    // ---------------- E: year-of-era numerator, time of day ----------------
    logic [DOE_W-1:0] r_e_t;
    t_doe             r_e_doe;
    t_year            r_e_yb;
    t_tod             r_e_tod;
    t_doe             x7;

    assign x7 = r_d_doe + DOE_W'(3);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_e_t <= r_d_doe - DOE_W'(r_d_q1460) + DOE_W'(r_d_q36524)
                   - DOE_W'(r_d_doe == DOE_W'(LAST_DOE));
            r_e_doe         <= r_d_doe;
            r_e_yb          <= r_d_yb;
            r_e_tod.hour    <= r_d_hour;
            r_e_tod.minute  <= 6'(r_d_mtot - MTOT_W'(r_d_hour) * MTOT_W'(60));
            r_e_tod.second  <= 6'(r_d_rem - REM_W'(r_d_mtot) * REM_W'(60));
            r_e_tod.weekday <= 3'(x7 - DOE_W'(r_d_q7) * DOE_W'(7));
        end
    end

    // ---------------- F: year of era ----------------
    t_yoe        r_f_yoe;
    t_doe        r_f_doe;
    t_year       r_f_yb;
    t_tod        r_f_tod;
    logic [36:0] p365;

    assign p365 = 37'(r_e_t) * 37'(M_DIV365);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_f_yoe <= p365[S_DIV365 +: YOE_W];
            r_f_doe <= r_e_doe;
            r_f_yb  <= r_e_yb;
            r_f_tod <= r_e_tod;
        end
    end

    // ---------------- G: day of March-based year, leap flag ----------------
    t_doy        r_g_doy;
    logic        r_g_leap;
    t_year       r_g_ysum;
    t_tod        r_g_tod;
    logic [18:0] p100;
    t_doe        yoe_days;

    assign p100     = 19'(r_f_yoe) * 19'(M_DIV100);
    assign yoe_days = DOE_W'(r_f_yoe) * DOE_W'(365) + DOE_W'(r_f_yoe >> 2)
                    - DOE_W'(p100[S_DIV100 +: 2]);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_g_doy  <= DOY_W'(r_f_doe - yoe_days);
            r_g_leap <= (r_f_yoe[1:0] == 2'd0) && (r_f_yoe != YOE_W'(100))
                     && (r_f_yoe != YOE_W'(200)) && (r_f_yoe != YOE_W'(300));
            r_g_ysum <= r_f_yb + YEAR_W'(r_f_yoe);
            r_g_tod  <= r_f_tod;
        end
    end

    // ---------------- H: March-based month ----------------
    t_mp         r_h_mp;
    t_doy        r_h_doy;
    logic        r_h_leap;
    t_year       r_h_ysum;
    t_tod        r_h_tod;
    logic [10:0] x153;
    logic [22:0] p153;

    assign x153 = {r_g_doy, 2'b00} + 11'(r_g_doy) + 11'd2;
    assign p153 = 23'(x153) * 23'(M_DIV153);

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_h_mp   <= p153[S_DIV153 +: MP_W];
            r_h_doy  <= r_g_doy;
            r_h_leap <= r_g_leap;
            r_h_ysum <= r_g_ysum;
            r_h_tod  <= r_g_tod;
        end
    end

    // ---------------- I: output register ----------------
    t_year      r_o_year;
    logic [3:0] r_o_mon;
    logic [4:0] r_o_dom;
    t_doy       r_o_yday;
    t_tod       r_o_tod;
    logic       jan_feb;

    assign jan_feb = r_h_mp >= MP_JANUARY;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_o_year <= r_h_ysum + YEAR_W'(jan_feb);
            r_o_mon  <= jan_feb ? r_h_mp - MP_JANUARY : r_h_mp + MP_W'(2);
            r_o_dom  <= 5'(r_h_doy - MP_DAYS_BEFORE[r_h_mp] + DOY_W'(1));
            r_o_yday <= jan_feb ? r_h_doy - DOY_W'(306)
                                : r_h_doy + DOY_W'(59) + DOY_W'(r_h_leap);
            r_o_tod  <= r_h_tod;
        end
    end

    assign o_out.valid            = r_v[NST-1];
    assign o_out.year_since_1900  = r_o_year;
    assign o_out.month_index      = r_o_mon;
    assign o_out.day_of_month     = r_o_dom;
    assign o_out.weekday          = r_o_tod.weekday;
    assign o_out.day_of_year      = r_o_yday;
    assign o_out.hour_of_day      = r_o_tod.hour;
    assign o_out.minute_of_hour   = r_o_tod.minute;
    assign o_out.second_of_minute = r_o_tod.second;

endmodule

>>> tb/tb_epoch_seconds_to_utc_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_utc_calendar
// Self-checking testbench for the epoch-seconds to UTC calendar converter.
// Each transfer into the block is converted to a civil date and time by an
// independent floor-division and 400-year-era calculation. The result is then
// queued and compared field by field against the next transfer out. A directed
// set of calendar corner dates runs first. After it come random times at day
// boundaries, era boundaries and across the full signed range. The stimulus
// runs under three back-pressure profiles on both handshake sides.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_utc_calendar import esc_pkg::*;;

    localparam int SECS_W       = 40;
    localparam int RANDOM_ITEMS = 430;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic signed [15:0] year;
        logic        [3:0]  month;
        logic        [4:0]  mday;
        logic        [2:0]  wday;
        logic        [8:0]  yday;
        logic        [4:0]  hour;
        logic        [5:0]  minute;
        logic        [5:0]  second;
    } t_calendar;

    class t_calendar_scoreboard;
        t_calendar pending_dates[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function longint floor_quot(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) < 0) q -= 1;
            return q;
        endfunction

        function longint floor_rem(longint a, longint b);
            longint r;
            r = a % b;
            if (r < 0) r += b;
            return r;
        endfunction

        function t_calendar civil_time(logic [SECS_W-1:0] raw);
            longint    secs, days, tod, z, era, doe, yoe, yr, doy, mp, dom, mon, yday;
            bit        leap;
            t_calendar c;
            secs = longint'($signed(raw));
            days = floor_quot(secs, SECS_PER_DAY);
            tod  = floor_rem(secs, SECS_PER_DAY);
            z    = days + CIVIL_SHIFT;
            era  = floor_quot(z, ERA_DAYS);
            doe  = z - era * ERA_DAYS;
            yoe  = (doe - doe / 1460 + doe / 36524 - doe / LAST_DOE) / 365;
            yr   = yoe + era * 400;
            doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp   = (5 * doy + 2) / 153;
            dom  = doy - (153 * mp + 2) / 5 + 1;
            leap = ((yoe % 4) == 0) && (((yoe % 100) != 0) || (yoe == 0));
            if (mp < 10) begin
                mon  = mp + 2;
                yday = doy + 59 + (leap ? 1 : 0);
            end else begin
                mon  = mp - 10;
                yday = doy - 306;
                yr   = yr + 1;
            end
            c.year   = 16'(yr - 1900);
            c.month  = 4'(mon);
            c.mday   = 5'(dom);
            c.wday   = 3'(floor_rem(days + 4, 7));
            c.yday   = 9'(yday);
            c.hour   = 5'(tod / 3600);
            c.minute = 6'((tod / 60) % 60);
            c.second = 6'(tod % 60);
            return c;
        endfunction

        function void note(logic [SECS_W-1:0] raw);
            pending_dates.push_back(civil_time(raw));
        endfunction

        function void compare_field(string name, longint exp, longint act);
            if (exp != act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
            end
        endfunction

        function void check(t_calendar got);
            t_calendar exp;
            if (pending_dates.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %p", $time, got);
                return;
            end
            exp = pending_dates.pop_front();
            compare_field("year_since_1900", exp.year, got.year);
            compare_field("month_index", exp.month, got.month);
            compare_field("day_of_month", exp.mday, got.mday);
            compare_field("weekday", exp.wday, got.wday);
            compare_field("day_of_year", exp.yday, got.yday);
            compare_field("hour_of_day", exp.hour, got.hour);
            compare_field("minute_of_hour", exp.minute, got.minute);
            compare_field("second_of_minute", exp.second, got.second);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;

    t_calendar_scoreboard sb;

    esc_in_if #(.EPOCH_SECONDS_WIDTH(SECS_W)) in_ch ();
    esc_out_if out_ch ();

    epoch_seconds_to_utc_calendar #(
        .EPOCH_SECONDS_WIDTH(SECS_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_epoch_seconds_to_utc_calendar: errors");
        $finish;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check('{out_ch.year_since_1900, out_ch.month_index, out_ch.day_of_month,
                       out_ch.weekday, out_ch.day_of_year, out_ch.hour_of_day,
                       out_ch.minute_of_hour, out_ch.second_of_minute});
        end
    end

    task automatic send_seconds(input logic [SECS_W-1:0] secs);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.epoch_seconds <= secs;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note(secs);
        @(negedge i_clk);
    endtask

    task automatic send_random_seconds();
        longint days, era, secs;
        int     sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            secs = longint'($signed(SECS_W'({$urandom(), $urandom()})));
        end else if (sel < 65) begin
            days = longint'($urandom_range(0, 12725826)) - 6362913;
            secs = days * SECS_PER_DAY + $urandom_range(0, 2) - 1;
        end else if (sel < 85) begin
            era  = longint'($urandom_range(0, 85)) - 38;
            days = era * ERA_DAYS - CIVIL_SHIFT + $urandom_range(0, 4) - 2;
            secs = days * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
        end else begin
            secs = longint'($signed($urandom()));
        end
        send_seconds(secs[SECS_W-1:0]);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending_dates.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        longint corner [$];
        sb                  = new();
        src_idle_pct        = 34;
        sink_idle_pct       = 67;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.epoch_seconds = '0;
        out_ch.ready        = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        corner = '{0, -1, 1, 86399, 86400, -86400, -86401,
                   (64'sd1 <<< (SECS_W - 1)) - 1, -(64'sd1 <<< (SECS_W - 1)),
                   951782400, 951868800, 978220800, 978307200,
                   2147483647, 64'sd2147483648, -64'sd2147483648,
                   -64'sd2208988800, -64'sd2203891200, 64'sd4107542400,
                   -64'sd62167219200, -64'sd62162035200, -64'sd62162035201,
                   -64'sd11644473600, -64'sd11644473601,
                   longint'($signed(40'h55_5555_5555)),
                   longint'($signed(40'hAA_AAAA_AAAA))};
        foreach (corner[i]) send_seconds(corner[i][SECS_W-1:0]);
        repeat (RANDOM_ITEMS) send_random_seconds();

        // hold off until the pipeline is empty
        wait_drained();
        src_idle_pct  = 67;
        sink_idle_pct = 34;
        repeat (RANDOM_ITEMS) send_random_seconds();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (RANDOM_ITEMS) send_random_seconds();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_dates.size() == 0) begin
            $display("tb_epoch_seconds_to_utc_calendar: clean");
        end else begin
            $display("tb_epoch_seconds_to_utc_calendar: errors");
        end
        $finish;
    end

endmodule
